>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the rgbyuv_checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on a given clock, disabled while the given reset is low
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assert a property on clk_i, disabled while rst_ni is low
`define ASSERT_STD(lbl, prop, msg) \
  `ASSERT_CLK_RST(lbl, clk_i, rst_ni, prop, msg)

`endif

>>> sv/rgbyuv_pkg.sv
// ----------------------------------------------------------------------------
// rgbyuv_pkg
// Shared constants, types and arithmetic for the RGB to YUV 4:2:0 converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rgbyuv_pkg;

  // Sizing
  localparam int DEFAULT_MAX_WIDTH = 4096;
  localparam int HEIGHT_LIMIT      = 4096;
  localparam int ROW_W             = 12;
  localparam int CFG_W             = 13;
  localparam int CFG_IDX_W         = 1;
  localparam int SAMPLE_W          = 8;
  localparam int PAIR_W            = 9;
  localparam int LINE_W            = 3 * PAIR_W;
  localparam int RESET_WIDTH       = 640;
  localparam int RESET_HEIGHT      = 480;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  // Horizontal pair sums of one 2-pixel group
  typedef struct packed {
    logic [PAIR_W-1:0] r;
    logic [PAIR_W-1:0] g;
    logic [PAIR_W-1:0] b;
  } pair_sum_t;

  // Luma: (77R + 150G + 29B) >> 8, the sum never exceeds 16 bits
  function automatic logic [SAMPLE_W-1:0] luma_of(input logic [SAMPLE_W-1:0] r,
                                                  input logic [SAMPLE_W-1:0] g,
                                                  input logic [SAMPLE_W-1:0] b);
    logic [15:0] acc;
    acc = 16'd77 * {8'd0, r} + 16'd150 * {8'd0, g} + 16'd29 * {8'd0, b};
    return acc[15:8];
  endfunction

  // Chroma: floor(t / 256) + 128, clamped to 0..255
  function automatic logic [SAMPLE_W-1:0] chroma_of(input logic signed [17:0] t);
    logic signed [17:0] s;
    s = t + 18'sd32768;
    if (s < 18'sd0) begin
      return 8'd0;
    end else if (s > 18'sd65535) begin
      return 8'd255;
    end
    return s[15:8];
  endfunction

endpackage

>>> sv/rgbyuv_line_ram.sv
// ----------------------------------------------------------------------------
// rgbyuv_line_ram
// Simple dual-port line memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgbyuv_line_ram #(
  parameter int DEPTH  = 2048,
  parameter int ADDR_W = 11,
  parameter int DATA_W = 27
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/rgb_to_yuv420_converter_unit.sv
// Pipeline: an accepted pixel passes stage 1, stage 2, stage 3 and the output register.
// Throughput: one pixel per cycle while the result sink does not stall; the line memory
// sees at most one access per pixel pair (a write on even rows, a read on odd rows).
// Reset: counters, pixel hold, stage valids and configuration registers return
// to defaults at once; the line memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// rgb_to_yuv420_converter_unit
// Streams RGB pixels in, gives luma per pixel and BT.601 chroma per 2x2 block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb_to_yuv420_converter_unit import rgbyuv_pkg::*; #(
  parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  // Pixel input
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [23:0]          s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
  // Result output
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [23:0]          m_axis_tdata,   // luma[7:0], chroma_u[15:8], chroma_v[23:16]
  output logic [0:0]           m_axis_tuser    // chroma_valid[0]
);

  localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WID_W      = $clog2(MAX_WIDTH + 1);
  localparam int CMP_W      = (WID_W > CFG_W) ? WID_W : CFG_W;
  localparam int RST_WID    = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;

  // Configuration registers, stored already clamped
  logic [WID_W-1:0] width_q, width_d;
  logic [CFG_W-1:0] height_q, height_d;
  logic [CMP_W-1:0] cfg_ext;

  assign cfg_ready_o = 1'b1;
  assign cfg_ext     = CMP_W'(cfg_data_i);

  // Clamp width and height on write
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_valid_i && cfg_reg_e'(cfg_index_i) == REG_FRAME_WIDTH) begin
      if (cfg_ext < CMP_W'(2)) begin
        width_d = WID_W'(2);
      end else if (cfg_ext > CMP_W'(MAX_WIDTH)) begin
        width_d = WID_W'(MAX_WIDTH);
      end else begin
        width_d = WID_W'(cfg_ext);
      end
    end
    if (cfg_valid_i && cfg_reg_e'(cfg_index_i) == REG_FRAME_HEIGHT) begin
      if (cfg_data_i < CFG_W'(2)) begin
        height_d = CFG_W'(2);
      end else if (cfg_data_i > CFG_W'(HEIGHT_LIMIT)) begin
        height_d = CFG_W'(HEIGHT_LIMIT);
      end else begin
        height_d = cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WID_W'(RST_WID);
      height_q <= CFG_W'(RESET_HEIGHT);
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  // Stage enables: a stage moves when it is empty or its successor moves
  logic v1_q, v2_q, v3_q, vo_q;
  logic en1, en2, en3, en_o;
  logic accept;

  assign en_o          = !vo_q || m_axis_tready;
  assign en3           = !v3_q || en_o;
  assign en2           = !v2_q || en3;
  assign en1           = !v1_q || en2;
  assign s_axis_tready = en1;
  assign accept        = s_axis_tvalid && en1;

  // Input fields
  logic [SAMPLE_W-1:0] in_r, in_g, in_b;
  assign in_r = s_axis_tdata[7:0];
  assign in_g = s_axis_tdata[15:8];
  assign in_b = s_axis_tdata[23:16];

  // Raster position
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [CMP_W-1:0] col_inc;
  logic [CFG_W-1:0] row_inc;
  logic             col_wrap, row_wrap;

  assign col_inc  = CMP_W'(col_q) + CMP_W'(1);
  assign col_wrap = col_inc >= CMP_W'(width_q);
  assign row_inc  = CFG_W'(row_q) + CFG_W'(1);
  assign row_wrap = row_inc >= height_q;

  // Advance column, wrap to the next row and frame
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      col_d = col_wrap ? '0 : COL_W'(col_inc);
      if (col_wrap) begin
        row_d = row_wrap ? '0 : ROW_W'(row_inc);
      end
    end
  end

  // Even-column pixel hold
  logic [SAMPLE_W-1:0] hold_r_q, hold_g_q, hold_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      hold_r_q <= '0;
      hold_g_q <= '0;
      hold_b_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (accept && !col_q[0]) begin
        hold_r_q <= in_r;
        hold_g_q <= in_g;
        hold_b_q <= in_b;
      end
    end
  end

  // Pair sums and line memory access: write on even rows, read on odd rows.
  // A write and a later read of one entry are at least two pixels apart, so
  // the read always sees the stored sums without forwarding.
  pair_sum_t           pair_in;
  logic                mem_we, mem_re;
  logic [ADDR_W-1:0]   mem_addr;
  logic [LINE_W-1:0]   mem_rdata;
  pair_sum_t           line_sum;

  assign pair_in.r = {1'b0, hold_r_q} + {1'b0, in_r};
  assign pair_in.g = {1'b0, hold_g_q} + {1'b0, in_g};
  assign pair_in.b = {1'b0, hold_b_q} + {1'b0, in_b};
  assign mem_we    = accept && col_q[0] && !row_q[0];
  assign mem_re    = accept && col_q[0] && row_q[0];
  assign mem_addr  = ADDR_W'(col_q >> 1);
  assign line_sum  = pair_sum_t'(mem_rdata);

  rgbyuv_line_ram #(
    .DEPTH  (LINE_DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (LINE_W)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_addr),
    .wdata_i (LINE_W'(pair_in)),
    .re_i    (mem_re),
    .raddr_i (mem_addr),
    .rdata_o (mem_rdata)
  );

  // Stage 1: pixel, pair sums, chroma flag (memory data arrives alongside)
  logic [SAMPLE_W-1:0] s1_r_q, s1_g_q, s1_b_q;
  pair_sum_t           s1_pair_q;
  logic                s1_chroma_q;

  // Stage 2: luma and block averages
  logic [SAMPLE_W-1:0] s2_luma_q, s2_ar_q, s2_ag_q, s2_ab_q;
  logic                s2_chroma_q;
  logic [PAIR_W:0]     sum_r, sum_g, sum_b;

  assign sum_r = {1'b0, s1_pair_q.r} + {1'b0, line_sum.r};
  assign sum_g = {1'b0, s1_pair_q.g} + {1'b0, line_sum.g};
  assign sum_b = {1'b0, s1_pair_q.b} + {1'b0, line_sum.b};

  // Stage 3: chroma weighted sums
  logic [SAMPLE_W-1:0] s3_luma_q;
  logic signed [17:0]  s3_tu_q, s3_tv_q;
  logic                s3_chroma_q;
  logic signed [17:0]  ar_s, ag_s, ab_s, tu, tv;

  assign ar_s = $signed({10'd0, s2_ar_q});
  assign ag_s = $signed({10'd0, s2_ag_q});
  assign ab_s = $signed({10'd0, s2_ab_q});
  assign tu   = 18'sd127 * ab_s - 18'sd43 * ar_s - 18'sd84 * ag_s;
  assign tv   = 18'sd127 * ar_s - 18'sd107 * ag_s - 18'sd20 * ab_s;

  // Output register
  logic [SAMPLE_W-1:0] o_luma_q, o_u_q, o_v_q;
  logic                o_chroma_q;

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en1) v1_q <= accept;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en_o) vo_q <= v3_q;
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_r_q      <= in_r;
      s1_g_q      <= in_g;
      s1_b_q      <= in_b;
      s1_pair_q   <= pair_in;
      s1_chroma_q <= mem_re;
    end
    if (en2) begin
      s2_luma_q   <= luma_of(s1_r_q, s1_g_q, s1_b_q);
      s2_ar_q     <= sum_r[PAIR_W:2];
      s2_ag_q     <= sum_g[PAIR_W:2];
      s2_ab_q     <= sum_b[PAIR_W:2];
      s2_chroma_q <= s1_chroma_q;
    end
    if (en3) begin
      s3_luma_q   <= s2_luma_q;
      s3_tu_q     <= tu;
      s3_tv_q     <= tv;
      s3_chroma_q <= s2_chroma_q;
    end
    if (en_o) begin
      o_luma_q   <= s3_luma_q;
      o_chroma_q <= s3_chroma_q;
      o_u_q      <= s3_chroma_q ? chroma_of(s3_tu_q) : '0;
      o_v_q      <= s3_chroma_q ? chroma_of(s3_tv_q) : '0;
    end
  end

  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = {o_v_q, o_u_q, o_luma_q};
  assign m_axis_tuser  = o_chroma_q;

endmodule

>>> sv/rgbyuv_checker.sv
// ----------------------------------------------------------------------------
// rgbyuv_checker
// Port-level checks on the converter's result stream, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rgbyuv_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  // Hold a stalled transaction unchanged
  `ASSERT_STD(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

  // Drive chroma to zero on pixels that close no block
  `ASSERT_STD(a_chroma_zero, m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[23:8] == 16'd0, "chroma not zero without a block")

  // Averaged samples keep U strictly inside the clamp limits
  `ASSERT_STD(a_u_range, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[15:8] != 8'd0 && m_axis_tdata[15:8] != 8'd255, "U out of reachable range")

  // Averaged samples keep V strictly inside the clamp limits
  `ASSERT_STD(a_v_range, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[23:16] != 8'd0 && m_axis_tdata[23:16] != 8'd255, "V out of reachable range")

endmodule

bind rgb_to_yuv420_converter_unit rgbyuv_checker u_rgbyuv_checker (.*);

>>> tb/sv/rgb_yuv_stream_checker.sv
// ----------------------------------------------------------------------------
// rgb_yuv_stream_checker
// Watches the configuration, pixel and result channels of the converter,
// predicts luma and 4:2:0 chroma for every accepted pixel and compares each
// accepted result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb_yuv_stream_checker import rgbyuv_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration write channel
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  // Pixel channel
  input  logic                 pix_valid_i,
  input  logic                 pix_ready_i,
  input  logic [23:0]          pix_data_i,   // red[7:0], green[15:8], blue[23:16]
  // Result channel
  input  logic                 res_valid_i,
  input  logic                 res_ready_i,
  input  logic [23:0]          res_data_i,   // luma[7:0], chroma_u[15:8], chroma_v[23:16]
  input  logic [0:0]           res_user_i,   // chroma_valid[0]
  // Status toward the testbench top
  output int                   pending_o,
  output int                   mismatch_count_o
);

  localparam int LINE_DEPTH = (DEFAULT_MAX_WIDTH + 1) / 2;

  typedef struct packed {
    logic [SAMPLE_W-1:0] luma;
    logic                chroma_valid;
    logic [SAMPLE_W-1:0] chroma_u;
    logic [SAMPLE_W-1:0] chroma_v;
  } yuv_result_t;

  // Shadow state of the converter
  pair_sum_t           even_row_sums [LINE_DEPTH];
  logic [SAMPLE_W-1:0] held_r, held_g, held_b;
  logic [ROW_W-1:0]    column_pos, row_pos;
  logic [CFG_W-1:0]    width_reg, height_reg;

  yuv_result_t expected_yuv_q [$];
  int          mismatches;

  // Register value as the block uses it: below 2 acts as 2, above the top as the top
  function automatic logic [CFG_W-1:0] effective_size(input logic [CFG_W-1:0] value,
                                                      input int top);
    if (value < CFG_W'(2)) return CFG_W'(2);
    if (value > CFG_W'(top)) return CFG_W'(top);
    return value;
  endfunction

  // floor(t / 256) + 128, saturated to the 8-bit range
  function automatic logic [SAMPLE_W-1:0] saturate_chroma(input int t);
    int shifted;
    shifted = (t + 32768) >>> 8;
    if (shifted < 0) return 8'd0;
    if (shifted > 255) return 8'd255;
    return shifted[SAMPLE_W-1:0];
  endfunction

  // Convert one pixel and advance the raster position
  function automatic yuv_result_t convert_pixel(input logic [SAMPLE_W-1:0] r,
                                                input logic [SAMPLE_W-1:0] g,
                                                input logic [SAMPLE_W-1:0] b);
    yuv_result_t       res;
    logic [15:0]       weighted;
    logic [PAIR_W-1:0] sum_r, sum_g, sum_b;
    pair_sum_t         upper;
    int                avg_r, avg_g, avg_b;
    logic [CFG_W-1:0]  next_col, next_row;

    res = '0;
    weighted = 16'd77 * r + 16'd150 * g + 16'd29 * b;
    res.luma = weighted[15:8];

    if (!column_pos[0]) begin
      // Hold the even-column pixel for its partner
      held_r = r;
      held_g = g;
      held_b = b;
    end else begin
      sum_r = held_r + r;
      sum_g = held_g + g;
      sum_b = held_b + b;
      if (!row_pos[0]) begin
        // Store the pair sums for the odd row below
        even_row_sums[column_pos[ROW_W-1:1]] = '{r: sum_r, g: sum_g, b: sum_b};
      end else begin
        // Average the 2x2 block and derive U and V
        upper = even_row_sums[column_pos[ROW_W-1:1]];
        avg_r = (int'(sum_r) + int'(upper.r)) >>> 2;
        avg_g = (int'(sum_g) + int'(upper.g)) >>> 2;
        avg_b = (int'(sum_b) + int'(upper.b)) >>> 2;
        res.chroma_u = saturate_chroma(-43 * avg_r - 84 * avg_g + 127 * avg_b);
        res.chroma_v = saturate_chroma(127 * avg_r - 107 * avg_g - 20 * avg_b);
        res.chroma_valid = 1'b1;
      end
    end

    // Wrap column, row and frame; a position past a shrunk limit wraps here too
    next_col = column_pos + 1'b1;
    if (next_col >= effective_size(width_reg, DEFAULT_MAX_WIDTH)) begin
      column_pos = '0;
      next_row = row_pos + 1'b1;
      if (next_row >= effective_size(height_reg, HEIGHT_LIMIT)) begin
        row_pos = '0;
      end else begin
        row_pos = next_row[ROW_W-1:0];
      end
    end else begin
      column_pos = next_col[ROW_W-1:0];
    end
    return res;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Predict on every pixel transaction, compare on every result transaction
  always @(posedge clk_i or negedge rst_ni) begin
    yuv_result_t want;
    if (!rst_ni) begin
      expected_yuv_q.delete();
      for (int i = 0; i < LINE_DEPTH; i++) begin
        even_row_sums[i] = '0;
      end
      held_r = '0;
      held_g = '0;
      held_b = '0;
      column_pos = '0;
      row_pos = '0;
      width_reg = CFG_W'(RESET_WIDTH);
      height_reg = CFG_W'(RESET_HEIGHT);
      mismatches = 0;
      pending_o <= 0;
      mismatch_count_o <= 0;
    end else begin
      if (pix_valid_i && pix_ready_i) begin
        expected_yuv_q.push_back(convert_pixel(pix_data_i[7:0], pix_data_i[15:8],
                                               pix_data_i[23:16]));
      end

      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_FRAME_WIDTH: begin
            width_reg = cfg_data_i;
          end
          REG_FRAME_HEIGHT: begin
            height_reg = cfg_data_i;
          end
          default: begin
          end
        endcase
      end

      if (res_valid_i && res_ready_i) begin
        if (expected_yuv_q.size() == 0) begin
          $error("result transaction with no pixel pending: luma %0d", res_data_i[7:0]);
          mismatches++;
        end else begin
          want = expected_yuv_q.pop_front();
          check_field("luma", want.luma, res_data_i[7:0]);
          check_field("chroma_valid", want.chroma_valid, res_user_i[0]);
          check_field("chroma_u", want.chroma_u, res_data_i[15:8]);
          check_field("chroma_v", want.chroma_v, res_data_i[23:16]);
        end
      end

      pending_o <= expected_yuv_q.size();
      mismatch_count_o <= mismatches;
    end
  end

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives pixel streams and frame-size writes into the RGB to YUV 4:2:0
// converter under random source and sink stalls; the stream checker beside
// the block predicts and compares every result, and this top gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import rgbyuv_pkg::*;

  localparam int STALL_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 12;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [23:0]          s_axis_tdata = '0;   // red[7:0], green[15:8], blue[23:16]
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [23:0]          m_axis_tdata;        // luma[7:0], chroma_u[15:8], chroma_v[23:16]
  logic [0:0]           m_axis_tuser;        // chroma_valid[0]

  int src_idle_pct = 8;
  int sink_idle_pct = 56;
  int stall_cycles = 0;
  int pending_results;
  int mismatch_count;

  rgb_to_yuv420_converter_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  rgb_yuv_stream_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .pix_valid_i      (s_axis_tvalid),
    .pix_ready_i      (s_axis_tready),
    .pix_data_i       (s_axis_tdata),
    .res_valid_i      (m_axis_tvalid),
    .res_ready_i      (m_axis_tready),
    .res_data_i       (m_axis_tdata),
    .res_user_i       (m_axis_tuser),
    .pending_o        (pending_results),
    .mismatch_count_o (mismatch_count)
  );

  // 50 MHz clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Stall the result sink at random
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // End the run when no transaction moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Black, white and the six primaries and secondaries, packed as tdata
  function automatic logic [23:0] primary_color(input logic [2:0] k);
    return {{8{k[2]}}, {8{k[1]}}, {8{k[0]}}};
  endfunction

  // Random pixel, each channel biased toward 0 and 255
  function automatic logic [23:0] random_pixel();
    logic [23:0] pix;
    pix = 24'($urandom());
    for (int c = 0; c < 3; c++) begin
      case ($urandom_range(5))
        0: begin
          pix[c*8 +: 8] = 8'h00;
        end
        1: begin
          pix[c*8 +: 8] = 8'hFF;
        end
        default: begin
        end
      endcase
    end
    return pix;
  endfunction

  // Mostly small frame sizes, now and then an extreme or any 13-bit value
  function automatic logic [CFG_W-1:0] random_size(input int typical_max);
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(4))
          0: return CFG_W'(0);
          1: return CFG_W'(1);
          2: return CFG_W'(2);
          3: return CFG_W'(4096);
          default: return {CFG_W{1'b1}};
        endcase
      end
      1: return CFG_W'($urandom());
      default: return CFG_W'($urandom_range(typical_max, 2));
    endcase
  endfunction

  // Mostly small widths, now and then one of 2 or below; never wider than the span
  // of line entries filled early on, so an odd row reads only stored sums
  function automatic logic [CFG_W-1:0] random_width(input int typical_max);
    case ($urandom_range(9))
      0: return CFG_W'($urandom_range(2));
      default: return CFG_W'($urandom_range(typical_max, 2));
    endcase
  endfunction

  // Offer one pixel after a random gap and hold it until the transaction
  task automatic send_pixel(input logic [23:0] pix);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= pix;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Drop the pixel stream and wait until every result has arrived
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results != 0);
  endtask

  // Write both frame-size registers back to back
  task automatic set_frame(input logic [CFG_W-1:0] width, input logic [CFG_W-1:0] height);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= REG_FRAME_WIDTH;
    cfg_data_i <= width;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= REG_FRAME_HEIGHT;
    cfg_data_i <= height;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Bursts of random pixels, often with a new frame size in between
  task automatic random_phase(input int src_pct, input int sink_pct, input int num_pixels);
    int sent;
    int burst;
    src_idle_pct = src_pct;
    sink_idle_pct = sink_pct;
    sent = 0;
    while (sent < num_pixels) begin
      if ($urandom_range(2) != 0) begin
        set_frame(random_width(24), random_size(6));
      end
      burst = $urandom_range(80, 20);
      repeat (burst) send_pixel(random_pixel());
      wait_drained();
      sent += burst;
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset sizes: extreme colors open row 0
    for (int k = 0; k < 8; k++) begin
      send_pixel(primary_color(k[2:0]));
    end
    wait_drained();

    // Oversized registers act as 4096: carry row 0 well past every width used
    // below, which fills the line entries that later odd rows read
    set_frame({CFG_W{1'b1}}, {CFG_W{1'b1}});
    repeat (200) send_pixel(random_pixel());
    wait_drained();

    // Width below 2 acts as 2; the column already past it wraps on the next pixel
    set_frame(CFG_W'(0), {CFG_W{1'b1}});
    repeat (5) send_pixel(random_pixel());
    wait_drained();

    // Height below 2 acts as 2; the row past it wraps to row 0 at the row end
    set_frame(CFG_W'(0), CFG_W'(1));
    repeat (2) send_pixel(random_pixel());
    wait_drained();

    // One uniform 2x2 frame per extreme color
    for (int k = 0; k < 8; k++) begin
      repeat (4) send_pixel(primary_color(k[2:0]));
    end
    wait_drained();

    // Odd width and odd height: trailing column and row give no chroma
    set_frame(CFG_W'(5), CFG_W'(3));
    repeat (15) send_pixel(random_pixel());
    wait_drained();

    // Shrink the width in the middle of an odd row
    set_frame(CFG_W'(16), CFG_W'(4));
    repeat (27) send_pixel(random_pixel());
    wait_drained();
    set_frame(CFG_W'(6), CFG_W'(4));
    repeat (13) send_pixel(random_pixel());
    wait_drained();

    // Shrink the height while the last of the old rows is still to come
    set_frame(CFG_W'(4), CFG_W'(4));
    repeat (12) send_pixel(random_pixel());
    wait_drained();
    set_frame(CFG_W'(4), CFG_W'(2));
    repeat (4) send_pixel(random_pixel());
    wait_drained();

    // Random traffic: slow sink, then slow source, then no stalls
    random_phase(8, 56, 300);
    random_phase(56, 8, 300);
    random_phase(0, 0, 300);

    // Catch stray results after the last expected one
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (pending_results != 0) begin
      $error("%0d expected results never arrived", pending_results);
    end
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
